// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ===== src/rqm_pkg.sv =====
package rqm_pkg;
	localparam int QueueDepthDef = 64;
	localparam int HandleBitsDef = 16;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_CHUNK = 2'd1;
	localparam logic [1:0] OP_SEND = 2'd2;
	localparam logic [1:0] OP_ACK = 2'd3;

	localparam logic [2:0] ST_DONE = 3'd0;
	localparam logic [2:0] ST_SENT = 3'd1;
	localparam logic [2:0] ST_NONE = 3'd2;
	localparam logic [2:0] ST_ACK_SENT = 3'd3;
	localparam logic [2:0] ST_ACK_PEND = 3'd4;
	localparam logic [2:0] ST_ACK_UNK = 3'd5;
	localparam logic [2:0] ST_REFUSED = 3'd6;

	localparam logic [1:0] REG_MAX_TOTAL = 2'd0;
	localparam logic [1:0] REG_WARN_TOTAL = 2'd1;
	localparam logic [1:0] REG_MAX_RESEND = 2'd2;
	localparam logic [1:0] REG_TIMEOUT = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [15:0] chunk_handle;
		logic [31:0] ack_id;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [15:0] sent_handle;
		logic [31:0] sent_id;
		logic overflow_dropped;
		logic [15:0] overflow_handle;
		logic retry_queued;
		logic expired_dropped;
		logic [15:0] expired_handle;
		logic near_full_warning;
		logic [6:0] occupancy;
	} rsp_t;
endpackage

// ===== src/rqm_if.sv =====
interface rqm_req_if import rqm_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rqm_rsp_if import rqm_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rqm_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [31:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== src/rqm_ring.sv =====
module rqm_ring import rqm_pkg::*; #(
	parameter int Depth = QueueDepthDef,
	parameter int Width = 56
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [1 << $clog2(Depth)];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== src/retransmit_queue_manager_top.sv =====
// New chunk: decode, then issue the result. Send: decode, read the pending head, write the sent entry, issue.
// Tick and ack: decode, an overflow drop (tick only), then compare each entry in turn, end a queue scan that
// runs off the end, shift entries on a removal, remove the entry, and issue the result.
// The worst case grows with QueueDepth, set by the one read port and one write port per queue.
// One word in flight at a time; the output register lets the next word in while a result waits.
// arst_n clears counters, time, sequence and registers to reset values; stores need no clear.
`include "assert_macros.svh"
module retransmit_queue_manager_top import rqm_pkg::*; #(
	parameter int QueueDepth = QueueDepthDef,
	parameter int HandleBits = HandleBitsDef
) (
	input logic clk,
	input logic arst_n,
	rqm_req_if.sink in_ch,
	rqm_rsp_if.source out_ch,
	rqm_cfg_if.sink cfg
);
	localparam int AW = $clog2(QueueDepth);
	localparam int CW = $clog2(QueueDepth + 1);
	localparam int PW = HandleBits + 40;
	localparam int SW = HandleBits + 72;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC = 4'd1;
	localparam logic [3:0] S_SRD = 4'd2;
	localparam logic [3:0] S_SCMP = 4'd3;
	localparam logic [3:0] S_PRD = 4'd4;
	localparam logic [3:0] S_PCMP = 4'd5;
	localparam logic [3:0] S_SHRD = 4'd6;
	localparam logic [3:0] S_SHWR = 4'd7;
	localparam logic [3:0] S_FIN = 4'd8;
	localparam logic [3:0] S_OUT = 4'd9;
	localparam logic [3:0] S_SENDRD = 4'd10;
	localparam logic [3:0] S_SENDWR = 4'd11;
	localparam logic [3:0] S_OVRD = 4'd12;
	localparam logic [3:0] S_OVDROP = 4'd13;

	logic [3:0] state_q;
	logic [6:0] max_total_q, warn_total_q;
	logic [7:0] max_resend_q;
	logic [31:0] timeout_q;
	logic [CW-1:0] pcnt_q, scnt_q;
	logic [AW-1:0] phead_q, shead_q;
	logic [31:0] seq_q, time_q;
	req_t req_q;
	rsp_t rsp_q;
	rsp_t out_q;
	rsp_t rsp_fin;
	logic out_valid_q;
	logic out_load;
	logic [CW-1:0] idx_q;
	logic shift_sent_q;
	logic [SW-1:0] hold_q;

	logic p_we, s_we;
	logic [AW-1:0] p_wa, p_ra, s_wa, s_ra;
	logic [PW-1:0] p_wd, p_rd;
	logic [SW-1:0] s_wd, s_rd;

	rqm_ring #(.Depth(QueueDepth), .Width(PW)) u_pend (
		.clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
	rqm_ring #(.Depth(QueueDepth), .Width(SW)) u_sent (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

	// pending entry: handle, id, attempts; sent entry adds send time
	logic [HandleBits-1:0] p_h, s_h;
	logic [31:0] p_id, s_id, s_at;
	logic [7:0] p_att, s_att;
	assign p_h = p_rd[PW-1 -: HandleBits];
	assign p_id = p_rd[39:8];
	assign p_att = p_rd[7:0];
	assign s_h = s_rd[SW-1 -: HandleBits];
	assign s_id = s_rd[71:40];
	assign s_att = s_rd[39:32];
	assign s_at = s_rd[31:0];

	logic [CW:0] total;
	logic [31:0] age;
	logic [15:0] h16_p, h16_s;
	assign total = {1'b0, pcnt_q} + {1'b0, scnt_q};
	assign age = time_q - s_at;
	assign h16_p = 16'(p_h);
	assign h16_s = 16'(s_h);

	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	always_comb begin
		rsp_fin = rsp_q;
		rsp_fin.occupancy = 7'(total);
	end

	always_comb begin
		p_we = 1'b0; s_we = 1'b0;
		p_wa = '0; s_wa = '0; p_wd = '0; s_wd = '0;
		p_ra = AW'(phead_q + AW'(idx_q));
		s_ra = AW'(shead_q + AW'(idx_q));
		unique case (state_q)
			S_DEC: begin
				if (req_q.opcode == OP_CHUNK && total < (CW+1)'(QueueDepth)) begin
					p_we = 1'b1;
					p_wa = AW'(phead_q + AW'(pcnt_q));
					p_wd = {HandleBits'(req_q.chunk_handle), 32'd0, 8'd0};
				end
			end
			S_SENDWR: begin
				s_we = 1'b1;
				s_wa = AW'(shead_q + AW'(scnt_q));
				s_wd = {p_h, seq_q, p_att, time_q};
			end
			S_SHRD: begin
				p_ra = AW'(phead_q + AW'(idx_q) - AW'(1));
				s_ra = AW'(shead_q + AW'(idx_q) - AW'(1));
			end
			S_SHWR: begin
				if (shift_sent_q) begin
					s_we = 1'b1; s_wa = AW'(shead_q + AW'(idx_q)); s_wd = s_rd;
				end else begin
					p_we = 1'b1; p_wa = AW'(phead_q + AW'(idx_q)); p_wd = p_rd;
				end
			end
			S_FIN: begin
				if (rsp_q.retry_queued) begin
					p_we = 1'b1;
					p_wa = AW'(phead_q - AW'(1));
					p_wd = {hold_q[SW-1 -: HandleBits], hold_q[71:40],
						hold_q[39:32] + 8'd1};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			max_total_q <= 7'd64; warn_total_q <= 7'd48;
			max_resend_q <= 8'd3; timeout_q <= 32'd1000;
			pcnt_q <= '0; scnt_q <= '0; phead_q <= '0; shead_q <= '0;
			seq_q <= '0; time_q <= '0; out_valid_q <= 1'b0;
			idx_q <= '0; shift_sent_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_MAX_TOTAL: max_total_q <= cfg.wdata[6:0];
					REG_WARN_TOTAL: warn_total_q <= cfg.wdata[6:0];
					REG_MAX_RESEND: max_resend_q <= cfg.wdata[7:0];
					REG_TIMEOUT: timeout_q <= cfg.wdata;
					default: ;
				endcase
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_ch.valid && in_ch.ready) begin
					req_q <= in_ch.data;
					rsp_q <= '0;
					idx_q <= '0;
					state_q <= S_DEC;
				end
				S_DEC: begin
					case (req_q.opcode)
						OP_CHUNK: begin
							if (total >= (CW+1)'(QueueDepth)) rsp_q.status <= ST_REFUSED;
							else pcnt_q <= pcnt_q + CW'(1);
							state_q <= S_OUT;
						end
						OP_SEND: begin
							if (pcnt_q == '0 || scnt_q == CW'(QueueDepth)) begin
								rsp_q.status <= ST_NONE;
								state_q <= S_OUT;
							end else begin
								seq_q <= seq_q + 32'd1;
								state_q <= S_SENDRD;
							end
						end
						OP_ACK: begin
							rsp_q.status <= ST_ACK_UNK;
							state_q <= S_SRD;
						end
						default: begin
							time_q <= time_q + 32'd1;
							if (total > (CW+1)'(max_total_q)) begin
								state_q <= (pcnt_q != '0) ? S_OVRD : S_SRD;
							end else begin
								rsp_q.near_full_warning <= total > (CW+1)'(warn_total_q);
								state_q <= S_SRD;
							end
						end
					endcase
				end
				S_OVRD: state_q <= S_OVDROP;
				S_OVDROP: begin
					rsp_q.overflow_dropped <= 1'b1;
					rsp_q.overflow_handle <= h16_p;
					phead_q <= phead_q + AW'(1);
					pcnt_q <= pcnt_q - CW'(1);
					state_q <= S_SRD;
				end
				S_SENDRD: state_q <= S_SENDWR;
				S_SENDWR: begin
					rsp_q.status <= ST_SENT;
					rsp_q.sent_handle <= h16_p;
					rsp_q.sent_id <= seq_q;
					phead_q <= phead_q + AW'(1);
					pcnt_q <= pcnt_q - CW'(1);
					scnt_q <= scnt_q + CW'(1);
					state_q <= S_OUT;
				end
				S_SRD: begin
					state_q <= (idx_q < scnt_q) ? S_SCMP :
						(req_q.opcode == OP_ACK) ? S_PRD : S_OUT;
					if (!(idx_q < scnt_q)) idx_q <= '0;
				end
				S_SCMP: begin
					if (req_q.opcode == OP_ACK ? (s_id == req_q.ack_id) : (age > timeout_q)) begin
						hold_q <= s_rd;
						shift_sent_q <= 1'b1;
						if (req_q.opcode == OP_ACK) rsp_q.status <= ST_ACK_SENT;
						else begin
							rsp_q.expired_handle <= h16_s;
							if (s_att < max_resend_q && pcnt_q < CW'(QueueDepth))
								rsp_q.retry_queued <= 1'b1;
							else rsp_q.expired_dropped <= 1'b1;
						end
						state_q <= S_SHWR;
						if (idx_q == '0) state_q <= S_FIN;
						else state_q <= S_SHRD;
					end else begin
						idx_q <= idx_q + CW'(1);
						state_q <= S_SRD;
					end
				end
				S_PRD: state_q <= (idx_q < pcnt_q) ? S_PCMP : S_OUT;
				S_PCMP: begin
					if (p_att != 8'd0 && p_id == req_q.ack_id) begin
						shift_sent_q <= 1'b0;
						rsp_q.status <= ST_ACK_PEND;
						state_q <= (idx_q == '0) ? S_FIN : S_SHRD;
					end else begin
						idx_q <= idx_q + CW'(1);
						state_q <= S_PRD;
					end
				end
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					idx_q <= idx_q - CW'(1);
					state_q <= (idx_q == CW'(1)) ? S_FIN : S_SHRD;
				end
				S_FIN: begin
					if (shift_sent_q) begin
						shead_q <= shead_q + AW'(1);
						scnt_q <= scnt_q - CW'(1);
					end else begin
						phead_q <= phead_q + AW'(1);
						pcnt_q <= pcnt_q - CW'(1);
					end
					if (rsp_q.retry_queued) begin
						phead_q <= phead_q - AW'(1);
						pcnt_q <= pcnt_q + CW'(1);
					end
					state_q <= S_OUT;
				end
				S_OUT: if (out_load) begin
					out_q <= rsp_fin;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_NEVER(a_total_bound, total > (CW+1)'(QueueDepth), "queues exceed depth")
	`ASSERT_NEVER(a_ready_busy, in_ch.ready && state_q != S_IDLE, "ready while busy")
	`ASSERT_NEVER(a_retry_drop, rsp_q.retry_queued && rsp_q.expired_dropped, "retry and drop")
	`ASSERT_CLK(a_out_after, $rose(out_valid_q) |-> $past(state_q) == S_OUT, "stray result")
endmodule
